// ===== src/deq_pkg.sv =====
// Shared types for the double-ended queue: command codes and cell chain ops.
// No dependencies; every other file in src/ uses this package.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CMD_W  = 3;

    // Command codes carried by the request channel
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5,
        CMD_CLEAR      = 3'd6
    } cmd_t;

    // Operation broadcast to every cell of one chain
    typedef enum logic [1:0] {
        OP_HOLD      = 2'd0,  // keep contents
        OP_SHIFT_IN  = 2'd1,  // move one cell away from the head, new value at the head
        OP_SHIFT_OUT = 2'd2,  // move one cell toward the head, head entry leaves
        OP_LOAD_AT   = 2'd3   // the cell whose index equals the count takes the value
    } chain_op_t;

    // Control for both chains for one transfer
    typedef struct packed {
        chain_op_t front_op;
        chain_op_t back_op;
    } chain_ctrl_t;

endpackage : deq_pkg

`default_nettype wire

// ===== src/deq_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on deq_pkg for the data and command widths.
`timescale 1ns / 1ps
`default_nettype none

interface deq_req_if;
    logic                               valid;
    logic                               ready;
    logic [deq_pkg::CMD_W-1:0]          command;
    logic signed [deq_pkg::DATA_W-1:0]  push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface : deq_req_if

interface deq_rsp_if #(
    parameter int unsigned COUNT_W = 7
);
    logic                               valid;
    logic                               ready;
    logic                               ok;
    logic signed [deq_pkg::DATA_W-1:0]  result_value;
    logic [COUNT_W-1:0]                 count;
    logic                               is_empty;

    modport source (output valid, output ok, output result_value, output count,
                    output is_empty, input ready);
    modport sink   (input valid, input ok, input result_value, input count,
                    input is_empty, output ready);
endinterface : deq_rsp_if

`default_nettype wire

// ===== src/double_ended_queue.sv =====
// Top level of the double-ended queue: command decode, count and response register.
// Depends on deq_pkg, deq_if and deq_chain.
//
// Usage
//   req carries a command and push_value; rsp returns ok, result_value, count and
//   is_empty, one response for every request transfer, in order.
//   Entries live twice: in a front chain of cells whose cell 0 is the front entry,
//   and in a back chain whose cell 0 is the back entry. A push at one end shifts
//   that end's chain and writes the other chain at the cell indexed by the count;
//   a pop shifts its own chain only. Both ends are therefore always at cell 0.
//   Throughput: one command per cycle for every command while rsp.ready is high, set by
//   the registered update of the two cell chains and the count register.
//   Latency: the response is valid in the cycle after the request transfer.
//   A stalled response holds in the output register; req.ready stays high while
//   rsp.ready is high, so a new request is taken in the same cycle that the
//   waiting response is taken.
//   Reset: count and the response valid clear at once; cell contents are not
//   reset and are only read while stored. No clearing pass is needed.
//   Unused command code seven answers with ok low and leaves the queue as is.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);

    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);
    localparam logic [COUNT_W-1:0] ONE        = COUNT_W'(1);

    logic                       accept;
    logic                       full;
    logic                       empty;
    logic [deq_pkg::DATA_W-1:0] front_head;
    logic [deq_pkg::DATA_W-1:0] back_head;
    deq_pkg::chain_ctrl_t       ctrl;

    logic [COUNT_W-1:0]         count_reg;
    logic [COUNT_W-1:0]         count_next;
    logic                       ok_next;
    logic [deq_pkg::DATA_W-1:0] res_next;

    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    logic                       ok_reg;
    logic [deq_pkg::DATA_W-1:0] res_reg;
    logic [COUNT_W-1:0]         rsp_count_reg;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == FULL_COUNT);
    assign empty     = (count_reg == '0);

    // Command decode: chain ops, new count and response
    always_comb
    begin
        ctrl.front_op = deq_pkg::OP_HOLD;
        ctrl.back_op  = deq_pkg::OP_HOLD;
        count_next    = count_reg;
        ok_next       = 1'b0;
        res_next      = '0;
        if (accept)
        begin
            unique case (deq_pkg::cmd_t'(req.command))
                deq_pkg::CMD_PUSH_FRONT:
                begin
                    if (!full)
                    begin
                        ctrl.front_op = deq_pkg::OP_SHIFT_IN;
                        ctrl.back_op  = deq_pkg::OP_LOAD_AT;
                        count_next    = count_reg + ONE;
                        ok_next       = 1'b1;
                    end
                end
                deq_pkg::CMD_PUSH_BACK:
                begin
                    if (!full)
                    begin
                        ctrl.front_op = deq_pkg::OP_LOAD_AT;
                        ctrl.back_op  = deq_pkg::OP_SHIFT_IN;
                        count_next    = count_reg + ONE;
                        ok_next       = 1'b1;
                    end
                end
                deq_pkg::CMD_POP_FRONT:
                begin
                    if (!empty)
                    begin
                        ctrl.front_op = deq_pkg::OP_SHIFT_OUT;
                        count_next    = count_reg - ONE;
                        ok_next       = 1'b1;
                        res_next      = front_head;
                    end
                end
                deq_pkg::CMD_POP_BACK:
                begin
                    if (!empty)
                    begin
                        ctrl.back_op = deq_pkg::OP_SHIFT_OUT;
                        count_next   = count_reg - ONE;
                        ok_next      = 1'b1;
                        res_next     = back_head;
                    end
                end
                deq_pkg::CMD_PEEK_FRONT:
                begin
                    if (!empty)
                    begin
                        ok_next  = 1'b1;
                        res_next = front_head;
                    end
                end
                deq_pkg::CMD_PEEK_BACK:
                begin
                    if (!empty)
                    begin
                        ok_next  = 1'b1;
                        res_next = back_head;
                    end
                end
                deq_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                    ok_next    = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    // Response valid: set on a request transfer, cleared when taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg        <= ok_next;
            res_reg       <= res_next;
            rsp_count_reg <= count_next;
        end
    end

    deq_chain #(
        .DEPTH   (DEPTH),
        .COUNT_W (COUNT_W)
    ) u_front_chain (
        .clk   (clk),
        .op    (ctrl.front_op),
        .value (req.push_value),
        .count (count_reg),
        .head  (front_head)
    );

    deq_chain #(
        .DEPTH   (DEPTH),
        .COUNT_W (COUNT_W)
    ) u_back_chain (
        .clk   (clk),
        .op    (ctrl.back_op),
        .value (req.push_value),
        .count (count_reg),
        .head  (back_head)
    );

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.ok           = ok_reg;
    assign rsp.result_value = res_reg;
    assign rsp.count        = rsp_count_reg;
    assign rsp.is_empty     = (rsp_count_reg == '0);

endmodule : double_ended_queue

`default_nettype wire

// ===== src/deq_cell.sv =====
// One storage cell of a queue chain: holds an entry and trades it with neighbors.
// Depends on deq_pkg for chain_op_t and DATA_W.
`timescale 1ns / 1ps
`default_nettype none

module deq_cell #(
    parameter int unsigned INDEX   = 0,
    parameter int unsigned COUNT_W = 7
) (
    input  wire logic                          clk,
    input  wire deq_pkg::chain_op_t            op,
    input  wire logic [deq_pkg::DATA_W-1:0]    value,
    input  wire logic [COUNT_W-1:0]            count,
    input  wire logic [deq_pkg::DATA_W-1:0]    near_data,  // neighbor toward the head
    input  wire logic [deq_pkg::DATA_W-1:0]    far_data,   // neighbor away from the head
    output logic      [deq_pkg::DATA_W-1:0]    data
);

    localparam logic [COUNT_W-1:0] MY_INDEX = COUNT_W'(INDEX);

    logic [deq_pkg::DATA_W-1:0] data_reg;
    logic [deq_pkg::DATA_W-1:0] data_next;

    // Next entry from the broadcast operation
    always_comb
    begin
        data_next = data_reg;
        unique case (op)
            deq_pkg::OP_HOLD:      data_next = data_reg;
            deq_pkg::OP_SHIFT_IN:  data_next = near_data;
            deq_pkg::OP_SHIFT_OUT: data_next = far_data;
            deq_pkg::OP_LOAD_AT:
            begin
                if (count == MY_INDEX)
                begin
                    data_next = value;
                end
            end
            default:               data_next = data_reg;
        endcase
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule : deq_cell

`default_nettype wire

// ===== src/deq_chain.sv =====
// A row of DEPTH cells with a fixed head at cell 0.
// Depends on deq_pkg and deq_cell.
`timescale 1ns / 1ps
`default_nettype none

module deq_chain #(
    parameter int unsigned DEPTH   = 64,
    parameter int unsigned COUNT_W = 7
) (
    input  wire logic                          clk,
    input  wire deq_pkg::chain_op_t            op,
    input  wire logic [deq_pkg::DATA_W-1:0]    value,
    input  wire logic [COUNT_W-1:0]            count,
    output logic      [deq_pkg::DATA_W-1:0]    head
);

    logic [deq_pkg::DATA_W-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [deq_pkg::DATA_W-1:0] near_d;
        logic [deq_pkg::DATA_W-1:0] far_d;

        // Head takes the new value on shift-in; the tail cell holds on shift-out
        if (i == 0)
        begin : g_head
            assign near_d = value;
        end
        else
        begin : g_mid
            assign near_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign far_d = cell_data[i];
        end
        else
        begin : g_body
            assign far_d = cell_data[i+1];
        end

        deq_cell #(
            .INDEX   (i),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .clk       (clk),
            .op        (op),
            .value     (value),
            .count     (count),
            .near_data (near_d),
            .far_data  (far_d),
            .data      (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule : deq_chain

`default_nettype wire

// ===== src/deq_checker.sv =====
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on deq_pkg and double_ended_queue.
`timescale 1ns / 1ps
`default_nettype none

module deq_checker #(
    parameter int unsigned DEPTH = 64
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               req_valid,
    input wire logic                               req_ready,
    input wire logic [deq_pkg::CMD_W-1:0]          req_command,
    input wire logic                               rsp_valid,
    input wire logic                               rsp_ready,
    input wire logic                               rsp_ok,
    input wire logic [deq_pkg::DATA_W-1:0]         rsp_result_value,
    input wire logic [$clog2(DEPTH + 1)-1:0]       rsp_count,
    input wire logic                               rsp_is_empty
);

    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

    // Clear always succeeds and leaves an empty queue in the next response
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_command == deq_pkg::CMD_CLEAR)
        |=> (rsp_valid && rsp_ok && rsp_count == '0))
        else $error("clear did not give an empty successful response");

    // A failed command returns zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ok) |-> (rsp_result_value == '0))
        else $error("failed command returned a nonzero value");

    // Count stays in range and agrees with the empty flag
    a_count_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_count <= COUNT_W'(DEPTH))
                       && (rsp_is_empty == (rsp_count == '0))))
        else $error("count out of range or empty flag mismatch");

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ok)
            && $stable(rsp_result_value) && $stable(rsp_count)))
        else $error("stalled response changed");

endmodule : deq_checker

bind double_ended_queue deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_command      (req.command),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_ok           (rsp.ok),
    .rsp_result_value (rsp.result_value),
    .rsp_count        (rsp.count),
    .rsp_is_empty     (rsp.is_empty)
);

`default_nettype wire

// ===== verif/double_ended_queue_tb.sv =====
// Self-checking bench for double_ended_queue: directed corner cases, then fill, drain and
// mixed command bursts under three idle patterns. Uses deq_pkg, deq_if and double_ended_queue.
`timescale 1ns / 1ps

module double_ended_queue_tb;

    localparam int unsigned DEPTH   = 64;
    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CMD_W   = deq_pkg::CMD_W;
    localparam int unsigned DATA_W  = deq_pkg::DATA_W;
    localparam int unsigned PHASE_ITEMS = 235;

    // code seven has no meaning; the block must ignore it
    localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] push_value;
    } deq_request_t;

    typedef struct packed {
        logic               ok;
        logic [DATA_W-1:0]  value;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } deq_response_t;

    logic clk;
    logic rst_n;

    deq_req_if                       req_ch ();
    deq_rsp_if #(.COUNT_W(COUNT_W))  rsp_ch ();

    double_ended_queue #(.DEPTH(DEPTH)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // requests waiting to be sent, responses still owed by the block
    deq_request_t  request_queue[$];
    deq_response_t expected_responses[$];

    // shadow copy of the queue contents
    logic [DATA_W-1:0]  shadow_ring [DEPTH];
    logic [ADDR_W-1:0]  shadow_head;
    logic [COUNT_W-1:0] shadow_count;

    int    send_idle_pct;
    int    recv_idle_pct;
    logic  req_taken;
    int    errors;
    int    n_requests;
    int    n_responses;
    int    n_full_push;
    int    n_empty_read;
    int    n_reserved;
    int    n_issued;
    int    plan_count;

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Bench limit
    initial
    begin
        #2_000_000;
        $display("Timeout at %0t ns with %0d responses outstanding", $time,
                 expected_responses.size());
        $display("Verification failed");
        $finish;
    end

    // Applies one command to the shadow queue and returns the response it should give
    function automatic deq_response_t apply_to_shadow(deq_request_t rq);
        deq_response_t      r;
        logic               full;
        logic               empty;
        logic [ADDR_W-1:0]  back_pos;

        r        = '0;
        full     = (shadow_count == COUNT_W'(DEPTH));
        empty    = (shadow_count == '0);
        back_pos = shadow_head + ADDR_W'(shadow_count - 1'b1);

        case (rq.command)
            deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    n_full_push++;
                end
                else if (rq.command == deq_pkg::CMD_PUSH_FRONT)
                begin
                    shadow_head              = shadow_head - 1'b1;
                    shadow_ring[shadow_head] = rq.push_value;
                    shadow_count++;
                    r.ok = 1'b1;
                end
                else
                begin
                    shadow_ring[shadow_head + ADDR_W'(shadow_count)] = rq.push_value;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_PEEK_FRONT:
            begin
                if (empty)
                begin
                    n_empty_read++;
                end
                else
                begin
                    r.value = shadow_ring[shadow_head];
                    r.ok    = 1'b1;
                    if (rq.command == deq_pkg::CMD_POP_FRONT)
                    begin
                        shadow_head = shadow_head + 1'b1;
                        shadow_count--;
                    end
                end
            end
            deq_pkg::CMD_POP_BACK, deq_pkg::CMD_PEEK_BACK:
            begin
                if (empty)
                begin
                    n_empty_read++;
                end
                else
                begin
                    r.value = shadow_ring[back_pos];
                    r.ok    = 1'b1;
                    if (rq.command == deq_pkg::CMD_POP_BACK)
                    begin
                        shadow_count--;
                    end
                end
            end
            deq_pkg::CMD_CLEAR:
            begin
                shadow_head  = '0;
                shadow_count = '0;
                r.ok         = 1'b1;
            end
            default:
            begin
                n_reserved++;
            end
        endcase

        r.count    = shadow_count;
        r.is_empty = (shadow_count == '0);
        return r;
    endfunction

    task automatic check_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: response %0d %s mismatch, expected %0h, got %0h",
                     $time, n_responses, field, want, got);
            errors++;
        end
    endtask

    // Driver: request and response ready change on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (req_ch.valid && !req_taken)
            begin
                // hold the current request until its transfer
            end
            else if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_ch.valid      <= 1'b1;
                req_ch.command    <= request_queue[0].command;
                req_ch.push_value <= request_queue[0].push_value;
            end
            else
            begin
                // idle: junk on the payload must be ignored
                req_ch.valid      <= 1'b0;
                req_ch.command    <= CMD_W'($urandom);
                req_ch.push_value <= $urandom;
            end
        end
    end

    // Monitor: both transfers are sampled on the rising edge
    always @(posedge clk)
    begin : monitor
        deq_response_t want;
        deq_request_t  sent_rq;

        if (!rst_n)
        begin
            req_taken = 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    $display("%0t ns: response with none outstanding, expected none, %s",
                             $time, "got:");
                    $display("    ok=%0b value=%0h count=%0d",
                             rsp_ch.ok, rsp_ch.result_value, rsp_ch.count);
                    errors++;
                end
                else
                begin
                    want = expected_responses[0];
                    expected_responses.delete(0);
                    check_field("ok", DATA_W'(want.ok), DATA_W'(rsp_ch.ok));
                    check_field("result_value", want.value, rsp_ch.result_value);
                    check_field("count", DATA_W'(want.count), DATA_W'(rsp_ch.count));
                    check_field("is_empty", DATA_W'(want.is_empty),
                                DATA_W'(rsp_ch.is_empty));
                end
                n_responses++;
            end

            req_taken = req_ch.valid && req_ch.ready;
            if (req_taken)
            begin
                sent_rq = request_queue[0];
                request_queue.delete(0);
                expected_responses.insert(expected_responses.size(),
                                          apply_to_shadow(sent_rq));
                n_requests++;
            end
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h7fff_ffff;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Queues one request and tracks the fill level for burst planning
    task automatic queue_request(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
        deq_request_t rq;

        rq.command    = cmd;
        rq.push_value = value;
        request_queue.insert(request_queue.size(), rq);
        if (cmd == CMD_RESERVED)
        begin
            return;
        end
        n_issued++;
        if ((cmd == deq_pkg::CMD_PUSH_FRONT || cmd == deq_pkg::CMD_PUSH_BACK)
            && plan_count < DEPTH)
        begin
            plan_count++;
        end
        else if ((cmd == deq_pkg::CMD_POP_FRONT || cmd == deq_pkg::CMD_POP_BACK)
                 && plan_count > 0)
        begin
            plan_count--;
        end
        else if (cmd == deq_pkg::CMD_CLEAR)
        begin
            plan_count = 0;
        end
    endtask

    // One burst: fill to full and overflow, drain to empty and underflow, or a mix
    task automatic queue_burst();
        int unsigned kind;
        int unsigned pick;

        kind = $urandom_range(9);
        if (kind < 3)
        begin
            while (plan_count < DEPTH)
            begin
                queue_request($urandom_range(1) ? deq_pkg::CMD_PUSH_FRONT
                                                : deq_pkg::CMD_PUSH_BACK, pick_value());
            end
            repeat ($urandom_range(1, 3))
            begin
                queue_request($urandom_range(1) ? deq_pkg::CMD_PUSH_FRONT
                                                : deq_pkg::CMD_PUSH_BACK, pick_value());
            end
            queue_request($urandom_range(1) ? deq_pkg::CMD_PEEK_FRONT
                                            : deq_pkg::CMD_PEEK_BACK, pick_value());
        end
        else if (kind < 6)
        begin
            while (plan_count > 0)
            begin
                pick = $urandom_range(9);
                if (pick < 8)
                begin
                    queue_request(pick[0] ? deq_pkg::CMD_POP_FRONT
                                          : deq_pkg::CMD_POP_BACK, pick_value());
                end
                else
                begin
                    queue_request(pick[0] ? deq_pkg::CMD_PEEK_FRONT
                                          : deq_pkg::CMD_PEEK_BACK, pick_value());
                end
            end
            repeat ($urandom_range(1, 2))
            begin
                pick = $urandom_range(3);
                queue_request(CMD_W'(deq_pkg::CMD_POP_FRONT) + CMD_W'(pick), pick_value());
            end
        end
        else
        begin
            repeat ($urandom_range(10, 40))
            begin
                pick = $urandom_range(99);
                if (pick < 22)
                    queue_request(deq_pkg::CMD_PUSH_FRONT, pick_value());
                else if (pick < 44)
                    queue_request(deq_pkg::CMD_PUSH_BACK, pick_value());
                else if (pick < 58)
                    queue_request(deq_pkg::CMD_POP_FRONT, pick_value());
                else if (pick < 72)
                    queue_request(deq_pkg::CMD_POP_BACK, pick_value());
                else if (pick < 82)
                    queue_request(deq_pkg::CMD_PEEK_FRONT, pick_value());
                else if (pick < 92)
                    queue_request(deq_pkg::CMD_PEEK_BACK, pick_value());
                else if (pick < 96)
                    queue_request(deq_pkg::CMD_CLEAR, pick_value());
                else
                    queue_request(CMD_RESERVED, pick_value());
            end
        end
    endtask

    // Sender holds off until the block has answered everything
    task automatic wait_drained();
        while (request_queue.size() > 0 || expected_responses.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_random_phase(int sender_idle, int receiver_idle);
        int start;

        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        start         = n_issued;
        while (n_issued - start < PHASE_ITEMS)
        begin
            queue_burst();
        end
        wait_drained();
    endtask

    // Stimulus
    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.command    = deq_pkg::CMD_PUSH_FRONT;
        req_ch.push_value = '0;
        rsp_ch.ready      = 1'b0;
        req_taken         = 1'b0;
        shadow_head       = '0;
        shadow_count      = '0;
        errors            = 0;
        n_requests        = 0;
        n_responses       = 0;
        n_full_push       = 0;
        n_empty_read      = 0;
        n_reserved        = 0;
        n_issued          = 0;
        plan_count        = 0;
        send_idle_pct     = 32;
        recv_idle_pct     = 78;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reads of an empty queue, the unused code, extreme values
        queue_request(deq_pkg::CMD_POP_FRONT, 32'h7fff_ffff);
        queue_request(deq_pkg::CMD_POP_BACK, '0);
        queue_request(deq_pkg::CMD_PEEK_FRONT, '1);
        queue_request(deq_pkg::CMD_PEEK_BACK, 32'h8000_0000);
        queue_request(CMD_RESERVED, 32'h1234_5678);
        queue_request(deq_pkg::CMD_PUSH_BACK, 32'h7fff_ffff);
        queue_request(deq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
        queue_request(deq_pkg::CMD_PUSH_BACK, '1);
        queue_request(deq_pkg::CMD_PUSH_FRONT, '0);
        queue_request(deq_pkg::CMD_PEEK_FRONT, '0);
        queue_request(deq_pkg::CMD_PEEK_BACK, '0);
        queue_request(CMD_RESERVED, '1);
        queue_request(deq_pkg::CMD_POP_BACK, '0);
        queue_request(deq_pkg::CMD_POP_FRONT, '0);
        queue_request(deq_pkg::CMD_PEEK_BACK, '0);
        queue_request(deq_pkg::CMD_CLEAR, 32'h5555_aaaa);
        queue_request(deq_pkg::CMD_PEEK_FRONT, '0);
        queue_request(deq_pkg::CMD_POP_BACK, '0);
        queue_request(deq_pkg::CMD_CLEAR, '0);
        queue_request(deq_pkg::CMD_PUSH_FRONT, 32'haaaa_5555);
        queue_request(deq_pkg::CMD_POP_BACK, '0);
        wait_drained();

        run_random_phase(32, 78);
        run_random_phase(78, 32);
        run_random_phase(0, 0);

        repeat (8) @(posedge clk);

        $display("Ran %0d requests, checked %0d responses: %0d pushes refused when full,",
                 n_requests, n_responses, n_full_push);
        $display("%0d pops or peeks refused when empty, %0d unused command codes ignored.",
                 n_empty_read, n_reserved);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("%0d mismatches found", errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== double_ended_queue.f =====
src/deq_pkg.sv
src/deq_if.sv
src/deq_cell.sv
src/deq_chain.sv
src/double_ended_queue.sv
src/deq_checker.sv
verif/double_ended_queue_tb.sv
